// ----- hdl/nv2r_pkg.sv -----
// ----------------------------------------------------------------------------
// nv2r_pkg
// Shared types, coefficients and helpers for the NV21 pixel to RGB block.
// ----------------------------------------------------------------------------
package nv2r_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int REG_DIM_W   = 12;
    localparam int COORD_W     = 11;
    localparam int OFFSET_W    = 24;
    localparam int SUM_W       = 22;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION     = 2'd2;

    localparam logic [REG_DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [REG_DIM_W-1:0] HEIGHT_RESET = 12'd480;

    // Rotation codes in quarter turns.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // BT.601 coefficients scaled by 1024.
    localparam logic signed [SUM_W-1:0] COEF_Y  = 22'sd1192;
    localparam logic signed [SUM_W-1:0] COEF_RV = 22'sd1634;
    localparam logic signed [SUM_W-1:0] COEF_GV = 22'sd832;
    localparam logic signed [SUM_W-1:0] COEF_GU = 22'sd400;
    localparam logic signed [SUM_W-1:0] COEF_BU = 22'sd2066;
    localparam logic [7:0]              LUMA_FLOOR = 8'd16;
    localparam int                      FRAC_BITS  = 10;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    // Floor shift by the fraction bits, then clamp to a byte.
    function automatic logic [7:0] sat_shift(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-FRAC_BITS-1:0] q;
        // Dropping the low bits of a two's complement value rounds toward minus infinity.
        q = s[SUM_W-1:FRAC_BITS];
        if (q < 0) begin
            return 8'd0;
        end else if (q > 255) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

// ----- hdl/nv2r_color.sv -----
// ----------------------------------------------------------------------------
// nv2r_color
// Fixed-point YUV to BGR conversion with luma floor and byte saturation.
// ----------------------------------------------------------------------------
module nv2r_color (
    input  logic [7:0]       luma,
    input  logic [7:0]       chroma_v,
    input  logic [7:0]       chroma_u,
    output nv2r_pkg::color_t color
);

    logic [7:0]                            y_off;
    logic signed [nv2r_pkg::SUM_W-1:0]     y_s;
    logic signed [nv2r_pkg::SUM_W-1:0]     v_s;
    logic signed [nv2r_pkg::SUM_W-1:0]     u_s;
    logic signed [nv2r_pkg::SUM_W-1:0]     a0;
    logic signed [nv2r_pkg::SUM_W-1:0]     sum_b;
    logic signed [nv2r_pkg::SUM_W-1:0]     sum_g;
    logic signed [nv2r_pkg::SUM_W-1:0]     sum_r;

    always_comb begin
        y_off = (luma < nv2r_pkg::LUMA_FLOOR) ? 8'd0 : luma - nv2r_pkg::LUMA_FLOOR;
        y_s   = signed'({14'd0, y_off});
        // Flipping the top bit of an offset-binary byte gives value minus 128.
        v_s   = {{14{~chroma_v[7]}}, ~chroma_v[7], chroma_v[6:0]};
        u_s   = {{14{~chroma_u[7]}}, ~chroma_u[7], chroma_u[6:0]};
        a0    = nv2r_pkg::COEF_Y * y_s;
        sum_b = a0 + nv2r_pkg::COEF_BU * u_s;
        sum_g = a0 - nv2r_pkg::COEF_GV * v_s - nv2r_pkg::COEF_GU * u_s;
        sum_r = a0 + nv2r_pkg::COEF_RV * v_s;
        color.blue  = nv2r_pkg::sat_shift(sum_b);
        color.green = nv2r_pkg::sat_shift(sum_g);
        color.red   = nv2r_pkg::sat_shift(sum_r);
    end

endmodule

// ----- hdl/nv2r_offset.sv -----
// ----------------------------------------------------------------------------
// nv2r_offset
// Rotated destination byte offset and frame range check for one pixel.
// ----------------------------------------------------------------------------
module nv2r_offset (
    input  logic [nv2r_pkg::REG_DIM_W-1:0] width,
    input  logic [nv2r_pkg::REG_DIM_W-1:0] height,
    input  logic [1:0]                     rotation,
    input  logic [nv2r_pkg::COORD_W-1:0]   row,
    input  logic [nv2r_pkg::COORD_W-1:0]   column,
    output logic [nv2r_pkg::OFFSET_W-1:0]  dest_offset,
    output logic                           in_range
);

    localparam int OP_W   = nv2r_pkg::REG_DIM_W + 1;
    localparam int PROD_W = 2 * OP_W;

    logic signed [OP_W-1:0]   w_s;
    logic signed [OP_W-1:0]   h_s;
    logic signed [OP_W-1:0]   i_s;
    logic signed [OP_W-1:0]   j_s;
    logic signed [OP_W-1:0]   op_a;
    logic signed [OP_W-1:0]   op_b;
    logic signed [OP_W-1:0]   op_c;
    logic signed [PROD_W-1:0] pos;

    always_comb begin
        w_s = signed'({1'b0, width});
        h_s = signed'({1'b0, height});
        i_s = signed'({2'b00, row});
        j_s = signed'({2'b00, column});
        // Every rotation reduces to pos = a * b + c; low bits wrap correctly.
        case (rotation)
            nv2r_pkg::ROT_0: begin
                op_a = i_s;
                op_b = w_s;
                op_c = j_s;
            end
            nv2r_pkg::ROT_90: begin
                op_a = j_s;
                op_b = h_s;
                op_c = w_s - 13'sd1 - i_s;
            end
            nv2r_pkg::ROT_180: begin
                op_a = w_s;
                op_b = h_s - 13'sd1 - i_s;
                op_c = w_s - 13'sd1 - j_s;
            end
            default: begin
                op_a = w_s - 13'sd1 - j_s;
                op_b = h_s;
                op_c = h_s - 13'sd1 - i_s;
            end
        endcase
        pos         = op_a * op_b + PROD_W'(op_c);
        dest_offset = {pos[nv2r_pkg::OFFSET_W-3:0], 2'b00};
        in_range    = ({1'b0, row} < height) && ({1'b0, column} < width);
    end

endmodule

// ----- hdl/nv21_pixel_to_rgb_rotate_top.sv -----
// ----------------------------------------------------------------------------
// nv21_pixel_to_rgb_rotate_top
// NV21 pixel to BGR conversion with rotated 4-byte-per-pixel frame offset.
// ----------------------------------------------------------------------------
// Pipeline: an accepted beat passes through the input register, then the
// result register, before its result is presented.
// Throughput: one beat per cycle while m_ready does not stall the result side,
// set by the single conversion and offset multiply stage between the two registers.
// Reset: synchronous, active low; clears both valid flags and loads
// frame width 640, frame height 480 and rotation 0.
module nv21_pixel_to_rgb_rotate_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_luma,
    input  logic [7:0]  s_chroma_v,
    input  logic [7:0]  s_chroma_u,
    input  logic [10:0] s_row,
    input  logic [10:0] s_column,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_green,
    output logic [7:0]  m_red,
    output logic [23:0] m_dest_offset,
    output logic        m_in_range
);

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [1:0]  rotation_reg;
    logic [11:0] width_cap;
    logic [11:0] height_cap;

    logic        s1_valid_reg;
    logic [7:0]  luma_reg;
    logic [7:0]  chroma_v_reg;
    logic [7:0]  chroma_u_reg;
    logic [10:0] row_reg;
    logic [10:0] column_reg;
    logic        s1_advance;

    nv2r_pkg::color_t color;
    logic [23:0]      offset;
    logic             in_range;

    logic             m_valid_reg;
    nv2r_pkg::color_t color_reg;
    logic [23:0]      dest_offset_reg;
    logic             in_range_reg;

    assign cfg_ready  = 1'b1;
    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= nv2r_pkg::WIDTH_RESET;
            height_reg   <= nv2r_pkg::HEIGHT_RESET;
            rotation_reg <= nv2r_pkg::ROT_0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                nv2r_pkg::REG_FRAME_WIDTH:  width_reg    <= cfg_data;
                nv2r_pkg::REG_FRAME_HEIGHT: height_reg   <= cfg_data;
                nv2r_pkg::REG_ROTATION:     rotation_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Register values above the frame limits are used as the limits.
    always_comb begin
        width_cap  = (int'(width_reg) > MAX_WIDTH) ? 12'(MAX_WIDTH) : width_reg;
        height_cap = (int'(height_reg) > MAX_HEIGHT) ? 12'(MAX_HEIGHT) : height_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            luma_reg     <= s_luma;
            chroma_v_reg <= s_chroma_v;
            chroma_u_reg <= s_chroma_u;
            row_reg      <= s_row;
            column_reg   <= s_column;
        end
    end

    nv2r_color u_color (
        .luma     (luma_reg),
        .chroma_v (chroma_v_reg),
        .chroma_u (chroma_u_reg),
        .color    (color)
    );

    nv2r_offset u_offset (
        .width       (width_cap),
        .height      (height_cap),
        .rotation    (rotation_reg),
        .row         (row_reg),
        .column      (column_reg),
        .dest_offset (offset),
        .in_range    (in_range)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
        if (s1_valid_reg && s1_advance) begin
            color_reg       <= color;
            dest_offset_reg <= offset;
            in_range_reg    <= in_range;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_blue        = color_reg.blue;
    assign m_green       = color_reg.green;
    assign m_red         = color_reg.red;
    assign m_dest_offset = dest_offset_reg;
    assign m_in_range    = in_range_reg;

    // A beat taken at the input is held in the first stage next cycle.
    a_s1_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted beat missing from input stage");

    // A stalled first stage keeps its beat.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("input stage dropped a stalled beat");

    // A beat leaving the first stage lands in the result register.
    a_m_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_advance) |=> m_valid_reg)
        else $error("result register missed a beat");

    // The input stage accepts whenever the result side can drain.
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) |-> s_ready)
        else $error("input stalled while result side is free");

endmodule
